/* rtl/core/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and helpers of the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int LIMIT_W     = 6;
    localparam int SYM_W       = 8;
    localparam int ERR_W       = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_MOD   = 8'h25;
    localparam logic [SYM_W-1:0] CH_POW   = 8'h5E;
    localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        K_ALNUM,
        K_OPEN,
        K_CLOSE,
        K_OPER
    } t_kind;

    typedef logic signed [2:0] t_rank;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        t_kind            kind;
        t_rank            rank;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [ERR_W-1:0] err;
        logic             last;
    } t_result;

    function automatic t_rank rank_of(input logic [SYM_W-1:0] c);
        t_rank r;
        case (c)
            CH_PLUS, CH_MINUS:        r = 3'sd1;
            CH_MUL, CH_DIV, CH_MOD:   r = 3'sd2;
            CH_POW:                   r = 3'sd3;
            CH_OPEN:                  r = 3'sd0;
            default:                  r = -3'sd1;
        endcase
        return r;
    endfunction

    function automatic logic is_alnum(input logic [SYM_W-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

/* rtl/core/itp_front.sv */
// ----------------------------------------------------------------------------
// itp_front
// Accepts input characters, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module itp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [itp_pkg::SYM_W-1:0]  i_s_tdata,
    input  logic                       i_s_tlast,
    output logic                       o_item_valid,
    output itp_pkg::t_item             o_item,
    input  logic                       i_item_pop
);
    import itp_pkg::*;

    t_item              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_fill, n_fill;
    logic               push;
    logic               pop;
    t_item              in_item;

    always_comb begin
        in_item.sym  = i_s_tdata;
        in_item.last = i_s_tlast;
        in_item.rank = rank_of(i_s_tdata);
        if (is_alnum(i_s_tdata)) begin
            in_item.kind = K_ALNUM;
        end else if (i_s_tdata == CH_OPEN) begin
            in_item.kind = K_OPEN;
        end else if (i_s_tdata == CH_CLOSE) begin
            in_item.kind = K_CLOSE;
        end else begin
            in_item.kind = K_OPER;
        end
    end

    assign o_s_tready   = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign push         = i_s_tvalid && o_s_tready;
    assign o_item_valid = (r_fill != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + QCNT_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_item;
        end
    end

endmodule

/* rtl/core/itp_back.sv */
// ----------------------------------------------------------------------------
// itp_back
// Operator stack sequencer: executes queued items, one stack step per cycle
// when not stalled; results pass a holding slot and an output register.
// ----------------------------------------------------------------------------
module itp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  itp_pkg::t_item              i_item,
    output logic                        o_item_pop,
    input  logic                        i_cfg_wr_en,
    input  logic [itp_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output itp_pkg::t_result            o_result
);
    import itp_pkg::*;

    typedef enum logic [1:0] {
        S_MAIN  = 2'b01,
        S_FLUSH = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SYM_W-1:0]   r_top;
    logic [SYM_W-1:0]   r_below;
    logic [SYM_W-1:0]   r_stack [STACK_DEPTH];
    t_result            r_pend;
    logic               r_pend_v;
    t_result            r_out;
    logic               r_out_v;

    logic [CNT_W-1:0]   lim;
    logic               full;
    logic               do_emit, do_push, do_pop, act_done, finish, go;
    logic [SYM_W-1:0]   emit_sym;
    logic [ERR_W-1:0]   emit_err;
    logic [CNT_W-1:0]   count_after;
    logic               out_free, emit_ok, emit_go, move;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb begin
        if ({1'b0, r_limit} > (LIMIT_W + 1)'(STACK_DEPTH)) begin
            lim = CNT_W'(STACK_DEPTH);
        end else begin
            lim = CNT_W'(r_limit);
        end
    end
    assign full = (r_count >= lim);

    always_comb begin
        do_emit  = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        act_done = 1'b0;
        emit_sym = r_top;
        emit_err = ERR_NONE;
        unique case (r_state)
            S_MAIN: begin
                unique case (i_item.kind)
                    K_ALNUM: begin
                        do_emit  = 1'b1;
                        emit_sym = i_item.sym;
                        act_done = 1'b1;
                    end
                    K_OPEN: begin
                        act_done = 1'b1;
                        if (full) begin
                            do_emit  = 1'b1;
                            emit_sym = '0;
                            emit_err = ERR_OVERFLOW;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                    K_CLOSE: begin
                        if (r_count == '0) begin
                            do_emit  = 1'b1;
                            emit_sym = '0;
                            emit_err = ERR_UNMATCHED;
                            act_done = 1'b1;
                        end else if (r_top == CH_OPEN) begin
                            do_pop   = 1'b1;
                            act_done = 1'b1;
                        end else begin
                            do_emit = 1'b1;
                            do_pop  = 1'b1;
                        end
                    end
                    K_OPER: begin
                        if ((r_count != '0) && (rank_of(r_top) >= i_item.rank)) begin
                            do_emit = 1'b1;
                            do_pop  = 1'b1;
                        end else begin
                            act_done = 1'b1;
                            if (full) begin
                                do_emit  = 1'b1;
                                emit_sym = '0;
                                emit_err = ERR_OVERFLOW;
                            end else begin
                                do_push = 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_FLUSH: begin
                do_emit = 1'b1;
                do_pop  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (do_push) begin
            count_after = r_count + CNT_W'(1);
        end else if (do_pop) begin
            count_after = r_count - CNT_W'(1);
        end else begin
            count_after = r_count;
        end
    end

    always_comb begin
        n_state = r_state;
        finish  = 1'b0;
        unique case (r_state)
            S_MAIN: begin
                if (act_done) begin
                    if (i_item.last && (count_after != '0)) begin
                        n_state = S_FLUSH;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (count_after == '0) begin
                    finish  = 1'b1;
                    n_state = S_MAIN;
                end
            end
            default: begin
                n_state = S_MAIN;
            end
        endcase
    end

    assign out_free   = !r_out_v || i_m_tready;
    assign emit_ok    = !r_pend_v || out_free;
    assign go         = i_item_valid && (!do_emit || emit_ok);
    assign emit_go    = go && do_emit;
    assign move       = r_pend_v && out_free && (r_pend.last || emit_go);
    assign o_item_pop = go && finish;
    assign n_count    = go ? count_after : r_count;
    assign rd_addr    = ADDR_W'(n_count - CNT_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_MAIN;
            r_limit  <= LIMIT_RESET;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (go) begin
                r_state <= n_state;
            end
            r_count <= n_count;
            if (emit_go) begin
                r_pend_v <= 1'b1;
            end else if (move) begin
                r_pend_v <= 1'b0;
            end
            if (move) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && do_push) begin
            r_stack[r_count[ADDR_W-1:0]] <= i_item.sym;
        end
        r_below <= r_stack[rd_addr];
        if (go && do_push) begin
            r_top <= i_item.sym;
        end else if (go && do_pop) begin
            r_top <= r_below;
        end
        if (emit_go) begin
            r_pend.sym  <= emit_sym;
            r_pend.err  <= emit_err;
            r_pend.last <= finish;
        end else if (go && finish && r_pend_v) begin
            r_pend.last <= 1'b1;
        end
        if (move) begin
            r_out <= r_pend;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_result   = r_out;

endmodule

/* rtl/core/infix_to_postfix_converter_unit.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix converter with a bounded operator stack.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer when           Carries
// s_axis    in   i_s_tvalid & o_s_tready  tdata symbol, tlast end_of_expr
// m_axis    out  o_m_tvalid & i_m_tready  tdata out_symbol, tuser error_code,
//                                         tlast last_of_run
// cfg       in   i_cfg_wr_en              stack_limit
//
// The back end takes one cycle per stack step unless it stalls: a plain
// item is one step, and each emitted pop (operator run, close parenthesis,
// end flush) one more; the '(' that a ')' discards is popped in its last step.
// The rate is set by one stack push or pop per step. A four-entry queue
// decouples input from the sequencer; results pass a holding slot and an
// output register, so the back end runs on while the output stalls until
// the slot fills. Reset empties the stack and queue and sets the limit to 32.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [itp_pkg::SYM_W-1:0]   i_s_tdata,   // [7:0] symbol
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [itp_pkg::SYM_W-1:0]   o_m_tdata,   // [7:0] out_symbol
    output logic [itp_pkg::ERR_W-1:0]   o_m_tuser,   // [1:0] error_code
    output logic                        o_m_tlast,
    input  logic                        i_cfg_wr_en,
    input  logic [itp_pkg::LIMIT_W-1:0] i_cfg_wr_data
);
    import itp_pkg::*;

    t_item   item;
    logic    item_valid;
    logic    item_pop;
    t_result result;

    itp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    itp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_result      (result)
    );

    assign o_m_tdata = result.sym;
    assign o_m_tuser = result.err;
    assign o_m_tlast = result.last;

endmodule
